// ----- rtl/ipv6w_pkg.sv -----
// Package for the IPv6 extension header walker.
// Holds the verdict and phase types, header type codes and byte positions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipv6w_pkg;

    // Default width of the packet byte counter.
    localparam int COUNT_BITS_DEF = 17;

    // Result field widths.
    localparam int OFFSET_BITS   = 17;
    localparam int EXT_CNT_BITS  = 13;
    localparam logic [EXT_CNT_BITS-1:0] EXT_CNT_MAX = '1;

    // Next-header type codes.
    localparam logic [7:0] HDR_HOP_BY_HOP = 8'd0;
    localparam logic [7:0] HDR_TCP        = 8'd6;
    localparam logic [7:0] HDR_ROUTING    = 8'd43;
    localparam logic [7:0] HDR_FRAGMENT   = 8'd44;
    localparam logic [7:0] HDR_DEST_OPTS  = 8'd60;

    // Version nibble of an IPv6 packet.
    localparam logic [3:0] VERSION_IPV6 = 4'd6;

    // Byte positions inside the fixed header.
    localparam int IDX_VERSION    = 0;
    localparam int IDX_PLEN_HI    = 4;
    localparam int IDX_PLEN_LO    = 5;
    localparam int IDX_NEXT_HDR   = 6;
    localparam int FIXED_HDR_LEN  = 40;
    localparam int IDX_FIXED_LAST = FIXED_HDR_LEN - 1;

    // Every chain header is looked at once its first eight bytes are in.
    localparam int EXT_UNIT_SHIFT = 3;
    localparam int EXT_LAST_BYTE  = 7;

    // Verdict codes.
    typedef enum logic [2:0] {
        V_OK        = 3'd0,
        V_TRUNC     = 3'd1,
        V_VERSION   = 3'd2,
        V_PAYLOAD   = 3'd3,
        V_FRAGMENT  = 3'd4,
        V_UNSUP     = 3'd5
    } t_verdict;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_FIXED     = 3'd0,
        PH_HDR       = 3'd1,
        PH_LEN       = 3'd2,
        PH_TAIL_SKIP = 3'd3,
        PH_TAIL_STOP = 3'd4,
        PH_DONE      = 3'd5
    } t_phase;

    // One result word.
    typedef struct packed {
        t_verdict                 verdict;
        logic [OFFSET_BITS-1:0]   tcp_offset;
        logic [EXT_CNT_BITS-1:0]  ext_header_count;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/ipv6w_in_stage.sv -----
// Input register of the IPv6 extension header walker.
// Holds one packet byte and its end mark until the parser takes it.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
`default_nettype none

module ipv6w_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_packet,
    input  wire logic       i_take,
    output logic            o_valid,
    output logic [7:0]      o_data_byte,
    output logic            o_end_of_packet
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_data_byte;
    logic       r_eop;
    logic       w_accept;

    // The register is free when empty or when its word leaves this cycle.
    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;
    assign n_valid  = w_accept || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data_byte <= i_data_byte;
            r_eop       <= i_end_of_packet;
        end
    end

    assign o_valid         = r_valid;
    assign o_data_byte     = r_data_byte;
    assign o_end_of_packet = r_eop;

endmodule

`default_nettype wire

// ----- rtl/ipv6w_parse.sv -----
// Header chain parser of the IPv6 extension header walker.
// Keeps the per-packet state and forms the verdict on the final byte.
// Depends on ipv6w_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv6w_parse #(
    parameter int COUNT_BITS = ipv6w_pkg::COUNT_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_packet,
    output logic            o_result_valid,
    output ipv6w_pkg::t_result o_result
);

    import ipv6w_pkg::*;

    localparam int SUM_W = COUNT_BITS + 1;
    localparam int WIDE_W = COUNT_BITS + OFFSET_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0]   r_byte_count, n_byte_count;
    t_phase                  r_phase, n_phase;
    logic [7:0]              r_next_header, n_next_header;
    logic [15:0]             r_payload_length, n_payload_length;
    logic [COUNT_BITS-1:0]   r_ext_start, n_ext_start;
    t_verdict                r_walk_result, n_walk_result;
    logic [COUNT_BITS-1:0]   r_tcp_start, n_tcp_start;
    logic [EXT_CNT_BITS-1:0] r_ext_count, n_ext_count;
    logic                    r_version_bad, n_version_bad;

    logic [COUNT_BITS-1:0]   w_idx;
    logic [SUM_W-1:0]        w_idx_ext;
    logic [SUM_W-1:0]        w_start_ext;
    logic [SUM_W-1:0]        w_next_start;
    logic [11:0]             w_hdr_bytes;
    logic [SUM_W-1:0]        w_plen_end;
    logic [WIDE_W-1:0]       w_tcp_wide;
    t_verdict                w_verdict;

    // Next-state logic for one byte, then the verdict from the updated state.
    always_comb begin
        n_byte_count     = r_byte_count;
        n_phase          = r_phase;
        n_next_header    = r_next_header;
        n_payload_length = r_payload_length;
        n_ext_start      = r_ext_start;
        n_walk_result    = r_walk_result;
        n_tcp_start      = r_tcp_start;
        n_ext_count      = r_ext_count;
        n_version_bad    = r_version_bad;

        w_idx        = r_byte_count;
        w_idx_ext    = {1'b0, r_byte_count};
        w_start_ext  = {1'b0, r_ext_start};
        w_hdr_bytes  = {3'b000, ({1'b0, i_data_byte} + 9'd1)} << EXT_UNIT_SHIFT;
        w_next_start = w_start_ext + SUM_W'(w_hdr_bytes);

        // A saturated counter stops the parse.
        if (w_idx != COUNT_MAX) begin
            n_byte_count = w_idx + 1'b1;
            case (r_phase)
                PH_FIXED: begin
                    if (w_idx == COUNT_BITS'(IDX_VERSION)) begin
                        n_version_bad = (i_data_byte[7:4] != VERSION_IPV6);
                    end
                    if (w_idx == COUNT_BITS'(IDX_PLEN_HI)) begin
                        n_payload_length[15:8] = i_data_byte;
                    end
                    if (w_idx == COUNT_BITS'(IDX_PLEN_LO)) begin
                        n_payload_length[7:0] = i_data_byte;
                    end
                    if (w_idx == COUNT_BITS'(IDX_NEXT_HDR)) begin
                        n_next_header = i_data_byte;
                    end
                    if (w_idx == COUNT_BITS'(IDX_FIXED_LAST)) begin
                        if (r_next_header == HDR_TCP) begin
                            n_walk_result = V_OK;
                            n_tcp_start   = COUNT_BITS'(FIXED_HDR_LEN);
                            n_phase       = PH_DONE;
                        end else begin
                            n_phase = PH_HDR;
                        end
                    end
                end
                PH_HDR: begin
                    if (w_idx == r_ext_start) begin
                        if (r_next_header inside {HDR_HOP_BY_HOP, HDR_DEST_OPTS,
                                                  HDR_ROUTING}) begin
                            n_next_header = i_data_byte;
                            n_phase       = PH_LEN;
                        end else begin
                            n_phase = PH_TAIL_STOP;
                        end
                    end
                end
                PH_LEN: begin
                    if (w_idx_ext == w_start_ext + SUM_W'(1)) begin
                        // Start of the following header, saturated to the counter range.
                        if (w_next_start[COUNT_BITS]) begin
                            n_tcp_start = COUNT_MAX;
                        end else begin
                            n_tcp_start = w_next_start[COUNT_BITS-1:0];
                        end
                        n_phase = PH_TAIL_SKIP;
                    end
                end
                PH_TAIL_SKIP: begin
                    if (w_idx_ext == w_start_ext + SUM_W'(EXT_LAST_BYTE)) begin
                        if (r_ext_count != EXT_CNT_MAX) begin
                            n_ext_count = r_ext_count + 1'b1;
                        end
                        n_ext_start = r_tcp_start;
                        if (r_next_header == HDR_TCP) begin
                            n_walk_result = V_OK;
                            n_phase       = PH_DONE;
                        end else begin
                            n_phase = PH_HDR;
                        end
                    end
                end
                PH_TAIL_STOP: begin
                    if (w_idx_ext == w_start_ext + SUM_W'(EXT_LAST_BYTE)) begin
                        n_walk_result = (r_next_header == HDR_FRAGMENT) ? V_FRAGMENT
                                                                        : V_UNSUP;
                        n_phase       = PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end

        // Verdict priority: length, version, payload length, chain outcome.
        w_plen_end = SUM_W'(n_payload_length) + SUM_W'(FIXED_HDR_LEN);
        if (n_byte_count < COUNT_BITS'(FIXED_HDR_LEN)) begin
            w_verdict = V_TRUNC;
        end else if (n_version_bad) begin
            w_verdict = V_VERSION;
        end else if (w_plen_end > {1'b0, n_byte_count}) begin
            w_verdict = V_PAYLOAD;
        end else begin
            w_verdict = n_walk_result;
        end
        w_tcp_wide = WIDE_W'(n_tcp_start);

        o_result.verdict          = w_verdict;
        o_result.tcp_offset       = (w_verdict == V_OK) ? w_tcp_wide[OFFSET_BITS-1:0]
                                                        : '0;
        o_result.ext_header_count = n_ext_count;

        // The final byte returns everything to its reset value.
        if (i_end_of_packet) begin
            n_byte_count     = '0;
            n_phase          = PH_FIXED;
            n_next_header    = '0;
            n_payload_length = '0;
            n_ext_start      = COUNT_BITS'(FIXED_HDR_LEN);
            n_walk_result    = V_TRUNC;
            n_tcp_start      = '0;
            n_ext_count      = '0;
            n_version_bad    = 1'b0;
        end
    end

    assign o_result_valid = i_en && i_end_of_packet;

    // State registers, advanced once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count     <= '0;
            r_phase          <= PH_FIXED;
            r_next_header    <= '0;
            r_payload_length <= '0;
            r_ext_start      <= COUNT_BITS'(FIXED_HDR_LEN);
            r_walk_result    <= V_TRUNC;
            r_tcp_start      <= '0;
            r_ext_count      <= '0;
            r_version_bad    <= 1'b0;
        end else if (i_en) begin
            r_byte_count     <= n_byte_count;
            r_phase          <= n_phase;
            r_next_header    <= n_next_header;
            r_payload_length <= n_payload_length;
            r_ext_start      <= n_ext_start;
            r_walk_result    <= n_walk_result;
            r_tcp_start      <= n_tcp_start;
            r_ext_count      <= n_ext_count;
            r_version_bad    <= n_version_bad;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ipv6w_out_stage.sv -----
// Output register of the IPv6 extension header walker.
// Holds one verdict word until the downstream side takes it.
// Depends on ipv6w_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv6w_out_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire ipv6w_pkg::t_result  i_result,
    output logic                     o_free,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output ipv6w_pkg::t_result       o_result
);

    import ipv6w_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Free when empty or when the held word is taken this cycle.
    assign o_free  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- rtl/ipv6_extension_header_walker_top.sv -----
// Top level of the IPv6 extension header walker.
// Depends on ipv6w_pkg, ipv6w_in_stage, ipv6w_parse and ipv6w_out_stage.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+------------------------------------------
//   input   | i_in_valid   | o_in_stall   | i_data_byte, i_end_of_packet
//   output  | o_out_valid  | i_out_stall  | o_verdict, o_tcp_offset, o_ext_header_count
//
// One byte is taken per cycle while the result register is free. The final byte
// passes the input register; its verdict word is then held in the result register.
// Reset is synchronous and active low and starts the parser at the fixed header.
// A stalled verdict holds the parser; the input register still takes one more byte.
`timescale 1ns / 1ps
`default_nettype none

module ipv6_extension_header_walker_top #(
    parameter int COUNT_BITS = ipv6w_pkg::COUNT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_packet,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_verdict,
    output logic [16:0]      o_tcp_offset,
    output logic [12:0]      o_ext_header_count
);

    import ipv6w_pkg::*;

    logic       w_byte_valid;
    logic [7:0] w_byte;
    logic       w_eop;
    logic       w_out_free;
    logic       w_take;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out_res;

    // A byte moves into the parser only when the result register can take a verdict.
    assign w_take = w_byte_valid && w_out_free;

    ipv6w_in_stage u_in (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .i_take          (w_take),
        .o_valid         (w_byte_valid),
        .o_data_byte     (w_byte),
        .o_end_of_packet (w_eop)
    );

    ipv6w_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_take),
        .i_data_byte     (w_byte),
        .i_end_of_packet (w_eop),
        .o_result_valid  (w_res_valid),
        .o_result        (w_res)
    );

    ipv6w_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_res_valid),
        .i_result (w_res),
        .o_free   (w_out_free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (w_out_res)
    );

    assign o_verdict          = w_out_res.verdict;
    assign o_tcp_offset       = w_out_res.tcp_offset;
    assign o_ext_header_count = w_out_res.ext_header_count;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the IPv6 extension header walker.
// Depends on ipv6w_pkg and ipv6_extension_header_walker_top; a scoreboard class predicts
// one verdict word per packet and checks each word that leaves the block.
`timescale 1ns / 1ps

module testbench;
    import ipv6w_pkg::*;

    localparam int CNT_W = COUNT_BITS_DEF;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int CLK_PERIOD = 20;
    localparam int IDLE_PCT = 34;
    localparam int MSG_LIMIT = 10;
    localparam int TOTAL_BYTES = 1550;
    localparam int DRAIN_CYCLES = 10;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PLEN_OVERFLOW = 70000;

    // Predicts the verdict word of each packet from the bytes accepted so far.
    class walker_scoreboard;
        logic [CNT_W-1:0]        seen;
        t_phase                  phase;
        logic [7:0]              hdr_type;
        logic [15:0]             plen;
        logic [CNT_W-1:0]        hdr_pos;
        t_verdict                chain_verdict;
        logic [CNT_W-1:0]        next_pos;
        logic [EXT_CNT_BITS-1:0] skipped;
        bit                      ver_bad;

        t_result pending[$];
        int      errors;
        int      results;
        int      packets;
        int      verdict_hits[6];

        function new();
            clear();
            errors = 0;
            results = 0;
            packets = 0;
        endfunction

        function void clear();
            seen = '0;
            phase = PH_FIXED;
            hdr_type = '0;
            plen = '0;
            hdr_pos = CNT_W'(FIXED_HDR_LEN);
            chain_verdict = V_TRUNC;
            next_pos = '0;
            skipped = '0;
            ver_bad = 1'b0;
        endfunction

        // Advances the header walk by one byte at position idx.
        function void walk_byte(int idx, logic [7:0] b);
            int pos;
            int span;
            pos = int'(hdr_pos);
            case (phase)
                PH_FIXED: begin
                    if (idx == IDX_VERSION) ver_bad = (b[7:4] != VERSION_IPV6);
                    if (idx == IDX_PLEN_HI) plen[15:8] = b;
                    if (idx == IDX_PLEN_LO) plen[7:0] = b;
                    if (idx == IDX_NEXT_HDR) hdr_type = b;
                    if (idx == IDX_FIXED_LAST) begin
                        if (hdr_type == HDR_TCP) begin
                            chain_verdict = V_OK;
                            next_pos = CNT_W'(FIXED_HDR_LEN);
                            phase = PH_DONE;
                        end else begin
                            phase = PH_HDR;
                        end
                    end
                end
                PH_HDR: begin
                    if (idx == pos) begin
                        if (hdr_type == HDR_HOP_BY_HOP || hdr_type == HDR_DEST_OPTS ||
                            hdr_type == HDR_ROUTING) begin
                            hdr_type = b;
                            phase = PH_LEN;
                        end else begin
                            phase = PH_TAIL_STOP;
                        end
                    end
                end
                PH_LEN: begin
                    if (idx == pos + 1) begin
                        // The next header start saturates at the top of the byte counter.
                        span = pos + ((int'(b) + 1) << EXT_UNIT_SHIFT);
                        if (span > CNT_MAX) span = CNT_MAX;
                        next_pos = CNT_W'(span);
                        phase = PH_TAIL_SKIP;
                    end
                end
                PH_TAIL_SKIP: begin
                    if (idx == pos + EXT_LAST_BYTE) begin
                        if (skipped != EXT_CNT_MAX) skipped++;
                        hdr_pos = next_pos;
                        if (hdr_type == HDR_TCP) begin
                            chain_verdict = V_OK;
                            phase = PH_DONE;
                        end else begin
                            phase = PH_HDR;
                        end
                    end
                end
                PH_TAIL_STOP: begin
                    if (idx == pos + EXT_LAST_BYTE) begin
                        chain_verdict = (hdr_type == HDR_FRAGMENT) ? V_FRAGMENT : V_UNSUP;
                        phase = PH_DONE;
                    end
                end
                default: ;
            endcase
        endfunction

        // Notes one accepted input word; the final byte of a packet queues a verdict.
        function void note_byte(logic [7:0] b, logic last);
            int       idx;
            t_verdict v;
            t_result  r;
            idx = int'(seen);
            if (idx < CNT_MAX) begin
                walk_byte(idx, b);
                seen = CNT_W'(idx + 1);
            end
            if (!last) return;
            if (seen < FIXED_HDR_LEN) v = V_TRUNC;
            else if (ver_bad) v = V_VERSION;
            else if (int'(plen) + FIXED_HDR_LEN > int'(seen)) v = V_PAYLOAD;
            else v = chain_verdict;
            r.verdict = v;
            r.tcp_offset = (v == V_OK) ? OFFSET_BITS'(next_pos) : '0;
            r.ext_header_count = skipped;
            pending.push_back(r);
            verdict_hits[int'(v)]++;
            packets++;
            clear();
        endfunction

        function void fail(string what);
            errors++;
            if (errors <= MSG_LIMIT) $display("[%0t] MISMATCH %s", $time, what);
        endfunction

        // Checks one accepted verdict word against the oldest prediction.
        function void check_result(logic [2:0] got_verdict, logic [16:0] got_offset,
                                   logic [12:0] got_count);
            t_result want;
            if (pending.size() == 0) begin
                fail($sformatf("unexpected verdict word: verdict %0d offset %0d count %0d",
                               got_verdict, got_offset, got_count));
                return;
            end
            want = pending.pop_front();
            results++;
            if (got_verdict !== want.verdict)
                fail($sformatf("packet %0d verdict: expected %0d, got %0d",
                               results, want.verdict, got_verdict));
            if (got_offset !== want.tcp_offset)
                fail($sformatf("packet %0d tcp_offset: expected %0d, got %0d",
                               results, want.tcp_offset, got_offset));
            if (got_count !== want.ext_header_count)
                fail($sformatf("packet %0d ext_header_count: expected %0d, got %0d",
                               results, want.ext_header_count, got_count));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        end_of_packet;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  verdict;
    logic [16:0] tcp_offset;
    logic [12:0] ext_count;

    bit               steady = 1'b0;
    int               bytes_sent = 0;
    logic [7:0]       pkt[$];
    walker_scoreboard sb = new();

    ipv6_extension_header_walker_top #(
        .COUNT_BITS(CNT_W)
    ) u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_data_byte        (data_byte),
        .i_end_of_packet    (end_of_packet),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_verdict          (verdict),
        .o_tcp_offset       (tcp_offset),
        .o_ext_header_count (ext_count)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Output side: check each accepted verdict word, then pick the next stall.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(verdict, tcp_offset, ext_count);
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // Sends one word, with random idle cycles ahead of it unless the run is steady.
    task automatic push_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_packet <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt[i]) push_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // Holds the sender until every predicted verdict has come out.
    task automatic wait_for_verdicts();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
    endtask

    function automatic void add_bytes(int n);
        repeat (n) pkt.push_back(8'($urandom));
    endfunction

    // Fixed header with a random low nibble in byte 0, the first header type in byte 6 and random filler elsewhere.
    function automatic void start_packet(logic [3:0] ver, logic [7:0] first_type);
        pkt.delete();
        pkt.push_back({ver, 4'($urandom)});
        add_bytes(FIXED_HDR_LEN - 1);
        pkt[IDX_NEXT_HDR] = first_type;
    endfunction

    // Extension header of (units + 1) * 8 bytes that names the header after it.
    function automatic void add_ext(logic [7:0] next_type, logic [7:0] units);
        pkt.push_back(next_type);
        pkt.push_back(units);
        add_bytes(((int'(units) + 1) << EXT_UNIT_SHIFT) - 2);
    endfunction

    // Payload length field set to the true payload plus extra, clipped to 16 bits.
    function automatic void fit_plen(int extra);
        int value;
        value = pkt.size() - FIXED_HDR_LEN + extra;
        if (value < 0) value = 0;
        if (value > 16'hFFFF) value = 16'hFFFF;
        pkt[IDX_PLEN_HI] = value[15:8];
        pkt[IDX_PLEN_LO] = value[7:0];
    endfunction

    function automatic void cut_to(int n);
        if (n < pkt.size()) pkt = pkt[0:n-1];
    endfunction

    function automatic logic [7:0] pick_skip();
        case ($urandom_range(2))
            0: return HDR_HOP_BY_HOP;
            1: return HDR_DEST_OPTS;
            default: return HDR_ROUTING;
        endcase
    endfunction

    // Header lengths are mostly short, with an occasional longer one.
    function automatic logic [7:0] ext_units();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85) return 8'($urandom_range(1));
        if (roll < 97) return 8'($urandom_range(2, 7));
        return 8'($urandom_range(8, 31));
    endfunction

    task automatic run_directed();
        // TCP right after the fixed header with no TCP bytes: offset equals packet length.
        start_packet(VERSION_IPV6, HDR_TCP);
        fit_plen(0);
        send_packet();
        // Data byte extremes after the fixed header.
        start_packet(VERSION_IPV6, HDR_TCP);
        pkt.push_back(8'hFF);
        pkt.push_back(8'h00);
        fit_plen(0);
        send_packet();
        // Every skipped header type in one chain.
        start_packet(VERSION_IPV6, HDR_HOP_BY_HOP);
        add_ext(HDR_DEST_OPTS, 8'd0);
        add_ext(HDR_ROUTING, 8'd1);
        add_ext(HDR_TCP, 8'd2);
        add_bytes(4);
        fit_plen(0);
        send_packet();
        // Fragment straight after the fixed header.
        start_packet(VERSION_IPV6, HDR_FRAGMENT);
        add_bytes(8);
        fit_plen(0);
        send_packet();
        // Fragment header cut short: still undecided, so truncated.
        start_packet(VERSION_IPV6, HDR_HOP_BY_HOP);
        add_ext(HDR_FRAGMENT, 8'd0);
        add_bytes(5);
        fit_plen(0);
        send_packet();
        // Unknown header types after a skipped header and after the fixed header.
        start_packet(VERSION_IPV6, HDR_HOP_BY_HOP);
        add_ext(8'd17, 8'd0);
        add_bytes(8);
        fit_plen(0);
        send_packet();
        start_packet(VERSION_IPV6, 8'hFF);
        add_bytes(8);
        fit_plen(0);
        send_packet();
        // A long run of packets with no idling on either side.
        steady = 1'b1;
        // Wrong version on a complete packet.
        start_packet(4'd4, HDR_TCP);
        add_bytes(20);
        fit_plen(0);
        send_packet();
        // Short packet with a wrong version: truncation wins.
        start_packet(4'hF, HDR_TCP);
        fit_plen(0);
        cut_to(FIXED_HDR_LEN - 1);
        send_packet();
        // Single-byte packet.
        pkt.delete();
        pkt.push_back(8'h00);
        send_packet();
        // Bare fixed header whose chain never starts.
        start_packet(VERSION_IPV6, HDR_HOP_BY_HOP);
        fit_plen(0);
        send_packet();
        // Payload length one too long, then at its maximum.
        start_packet(VERSION_IPV6, HDR_TCP);
        add_bytes(10);
        fit_plen(1);
        send_packet();
        start_packet(VERSION_IPV6, HDR_TCP);
        add_bytes(3);
        fit_plen(PLEN_OVERFLOW);
        send_packet();
        // Bad version outranks a payload length that is too long.
        start_packet(4'd0, HDR_TCP);
        fit_plen(5);
        send_packet();
        // Largest header length byte, cut after the first twelve bytes of that header.
        start_packet(VERSION_IPV6, HDR_DEST_OPTS);
        add_ext(HDR_TCP, 8'd255);
        cut_to(FIXED_HDR_LEN + 12);
        fit_plen(0);
        send_packet();
        // Routing header cut in its middle.
        start_packet(VERSION_IPV6, HDR_ROUTING);
        add_ext(HDR_TCP, 8'd0);
        fit_plen(0);
        cut_to(FIXED_HDR_LEN + 3);
        send_packet();
        // Payload length shorter than the bytes that follow.
        start_packet(VERSION_IPV6, HDR_TCP);
        add_bytes(12);
        fit_plen(-7);
        send_packet();
        // Packet ends exactly where the TCP header would start.
        start_packet(VERSION_IPV6, HDR_HOP_BY_HOP);
        add_ext(HDR_TCP, 8'd3);
        fit_plen(0);
        send_packet();
        steady = 1'b0;
        // Two skipped headers and then an unsupported one.
        start_packet(VERSION_IPV6, HDR_ROUTING);
        add_ext(HDR_HOP_BY_HOP, 8'd0);
        add_ext(8'd59, 8'd1);
        add_bytes(8);
        fit_plen(0);
        send_packet();
        // Fragment after a destination options header.
        start_packet(VERSION_IPV6, HDR_DEST_OPTS);
        add_ext(HDR_FRAGMENT, 8'd0);
        add_bytes(8);
        fit_plen(0);
        send_packet();
    endtask

    // Mostly well-formed chains with random content; the rest carry broken fields.
    task automatic random_packet();
        int         kind;
        int         hops;
        int         roll;
        logic [3:0] ver;
        logic [7:0] last_type;
        logic [7:0] chain[$];
        kind = $urandom_range(99);
        if (kind >= 97) begin
            pkt.delete();
            add_bytes($urandom_range(1, 60));
            send_packet();
            return;
        end
        ver = VERSION_IPV6;
        if (kind >= 85 && kind < 90) begin
            ver = 4'($urandom_range(15));
            if (ver == VERSION_IPV6) ver = 4'd4;
        end
        hops = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(3);
        roll = $urandom_range(99);
        last_type = (roll < 80) ? HDR_TCP : (roll < 90) ? HDR_FRAGMENT : 8'($urandom);
        repeat (hops) chain.push_back(pick_skip());
        chain.push_back(last_type);
        start_packet(ver, chain[0]);
        for (int h = 1; h < chain.size(); h++) add_ext(chain[h], ext_units());
        if (last_type == HDR_TCP) add_bytes($urandom_range(8));
        else add_bytes($urandom_range(6, 12));
        if (kind < 70) fit_plen(0);
        else if (kind < 78)
            fit_plen(($urandom_range(3) == 0) ? PLEN_OVERFLOW : $urandom_range(1, 300));
        else if (kind < 85) fit_plen(0 - int'($urandom_range(1, 40)));
        else fit_plen(0);
        if (kind >= 90) cut_to($urandom_range(1, pkt.size()));
        send_packet();
    endtask

    initial begin
        in_valid <= 1'b0;
        data_byte <= '0;
        end_of_packet <= 1'b0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_for_verdicts();

        while (bytes_sent < TOTAL_BYTES) random_packet();

        wait_for_verdicts();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Walked %0d packets in %0d bytes, directed chains then random ones,",
                 sb.packets, bytes_sent);
        $display("with idle and stall phases; %0d verdict words checked.", sb.results);
        $display("Verdicts: ok %0d, truncated %0d, version %0d, payload %0d,",
                 sb.verdict_hits[V_OK], sb.verdict_hits[V_TRUNC], sb.verdict_hits[V_VERSION],
                 sb.verdict_hits[V_PAYLOAD]);
        $display("fragment %0d, unsup %0d",
                 sb.verdict_hits[V_FRAGMENT], sb.verdict_hits[V_UNSUP]);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches in total", sb.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d verdict words still outstanding", sb.pending.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- ipv6_extension_header_walker_top.f -----
rtl/ipv6w_pkg.sv
rtl/ipv6w_in_stage.sv
rtl/ipv6w_parse.sv
rtl/ipv6w_out_stage.sv
rtl/ipv6_extension_header_walker_top.sv
verif/testbench.sv
